@@ rtl/core/skhi_pkg.sv @@
// Shared types and constants for the string key hash index core.
// Holds the CRC-32 byte table, the queue sizing and the mix step functions.
// No dependencies.
package skhi_pkg;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] GOLDEN_MULT = 32'd2654435761;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_W    = 5;
  localparam int BUCKET_W = 31;

  typedef logic [31:0] crc_table_t [256];

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Reflected CRC-32 table, built at elaboration.
  function automatic crc_table_t build_crc_table();
    crc_table_t  tbl;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      tbl[i] = c;
    end
    return tbl;
  endfunction

  localparam crc_table_t CRC_TABLE = build_crc_table();

  // First four steps of the 32-bit integer mix.
  function automatic logic [31:0] mix_lo(input logic [31:0] k_in);
    logic [31:0] k;
    k = k_in;
    k = k + (k << 12);
    k = k ^ (k >> 22);
    k = k + (k << 4);
    k = k ^ (k >> 9);
    return k;
  endfunction

  // Last four steps of the 32-bit integer mix.
  function automatic logic [31:0] mix_hi(input logic [31:0] k_in);
    logic [31:0] k;
    k = k_in;
    k = k + (k << 10);
    k = k ^ (k >> 2);
    k = k + (k << 7);
    k = k ^ (k >> 12);
    return k;
  endfunction

endpackage

@@ rtl/core/skhi_front.sv @@
// Front end: takes key bytes, runs the CRC-32 per byte, pushes the
// finished CRC of each key into the queue. Depends on skhi_pkg.
module skhi_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              key_byte,
  input  logic                    is_last,
  input  skhi_pkg::queue_status_t q_status,
  output logic                    push,
  output logic [31:0]             push_crc
);

  logic [31:0] crc;
  logic [31:0] crc_next;
  logic [7:0]  tbl_idx;
  logic        accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign tbl_idx  = crc[7:0] ^ key_byte;
  assign crc_next = (crc >> 8) ^ skhi_pkg::CRC_TABLE[tbl_idx];
  assign push     = accept && is_last;
  assign push_crc = crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0;
    end else if (accept) begin
      crc <= is_last ? 32'd0 : crc_next;
    end
  end

endmodule

@@ rtl/core/skhi_queue.sv @@
// Short queue of finished key CRCs between front and back.
// Depends on skhi_pkg for depth and status type.
module skhi_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [31:0]             push_data,
  input  logic                    pop,
  output logic [31:0]             head_data,
  output skhi_pkg::queue_status_t status
);

  logic [31:0]                      slots [skhi_pkg::QUEUE_DEPTH];
  logic [skhi_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [skhi_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [skhi_pkg::QUEUE_CNT_W-1:0] count;

  assign head_data    = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == skhi_pkg::QUEUE_CNT_W'(skhi_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/skhi_back.sv @@
// Back end: mix, shift, multiply and mask, three register stages with
// per-stage valid and local stall. Depends on skhi_pkg.
module skhi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  logic [31:0]                head_crc,
  output logic                       pop,
  input  logic [skhi_pkg::CFG_W-1:0] table_size_log2,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [30:0]                bucket_index,
  output logic [31:0]                mixed_hash
);

  logic        v1, v2, v3;
  logic [31:0] s1_mix;
  logic [28:0] s2_hash;
  logic        en1, en2, en3;
  logic [31:0] mask;
  logic [31:0] h_full;

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pop = !q_empty && en1;

  assign h_full = skhi_pkg::mix_hi(s1_mix);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= pop;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && pop) s1_mix <= skhi_pkg::mix_lo(head_crc);
    if (en2 && v1)  s2_hash <= h_full[31:3];
    if (en3 && v2)  mixed_hash <= 32'({3'b000, s2_hash} * skhi_pkg::GOLDEN_MULT);
  end

  // User must set table size while idle (unchecked); mask sits at output.
  assign mask         = (32'd1 << table_size_log2) - 32'd1;
  assign bucket_index = mixed_hash[30:0] & mask[30:0];
  assign out_valid    = v3;

endmodule

@@ rtl/core/string_key_hash_index_core.sv @@
// Top level of the string key hash index core.
// Depends on skhi_pkg, skhi_front, skhi_queue and skhi_back.
//
// Key bytes come in on the in_valid/in_ready channel, one byte per transfer,
// with is_last set on the final byte of each key. Each byte updates a running
// reflected CRC-32 through a 256-entry table, one byte per cycle while
// in_ready is high. On the last byte the CRC goes into a four-entry queue
// and the accumulator clears. The back end pulls CRCs from the queue through
// three stages: mix first half, mix second half and shift, multiply. One
// result per key leaves on out_valid/out_ready: mixed_hash and
// bucket_index = mixed_hash masked to table_size_log2 bits. Throughput: one
// byte per cycle while in_ready is high, set by the single table step in
// the front. When the receiver stalls, the back stages fill, then the
// queue; in_ready drops only once the queue is full. table_size_log2 is
// written through cfg_we/cfg_wdata; the user must write it only while
// idle, which the block does not enforce. Reset clears the CRC, empties
// the queue and pipeline, and sets table_size_log2 to 8.
module string_key_hash_index_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 key_byte,
  input  logic                       is_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [30:0]                bucket_index,
  output logic [31:0]                mixed_hash,
  input  logic                       cfg_we,
  input  logic [skhi_pkg::CFG_W-1:0] cfg_wdata
);

  logic [skhi_pkg::CFG_W-1:0] table_size_log2;
  skhi_pkg::queue_status_t    q_status;
  logic                       push;
  logic [31:0]                push_crc;
  logic                       pop;
  logic [31:0]                head_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size_log2 <= skhi_pkg::CFG_W'(8);
    end else if (cfg_we) begin
      table_size_log2 <= cfg_wdata;
    end
  end

  skhi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .key_byte (key_byte),
    .is_last  (is_last),
    .q_status (q_status),
    .push     (push),
    .push_crc (push_crc)
  );

  skhi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_crc),
    .pop       (pop),
    .head_data (head_crc),
    .status    (q_status)
  );

  skhi_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_status.empty),
    .head_crc        (head_crc),
    .pop             (pop),
    .table_size_log2 (table_size_log2),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .bucket_index    (bucket_index),
    .mixed_hash      (mixed_hash)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("queue pop while empty");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (q_status.empty && !out_valid))
    else $error("queue or output not clear after reset");

endmodule

@@ sim/string_key_hash_index_core_tb.sv @@
// Self-checking testbench for string_key_hash_index_core: streams keys byte by byte
// and checks every bucket_index / mixed_hash against a CRC-32 + mix predictor or typed row.
// Depends on skhi_pkg and the core RTL only.
module string_key_hash_index_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 80;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_BYTES  = 150;
  localparam int PRESSURE_PH  = 2;

  typedef struct {
    logic [30:0] bucket;
    logic [31:0] hash;
  } hash_result_t;

  // Directed stimulus row: optional table size write first, then one key byte.
  // Where typed is set the expected result is taken from eb/eh.
  typedef struct packed {
    logic        do_cfg;
    logic [4:0]  cfg;
    logic [7:0]  b;
    logic        last;
    logic        typed;
    logic [30:0] eb;
    logic [31:0] eh;
  } key_row_t;

  localparam int NUM_ROWS = 22;
  localparam key_row_t KEY_ROWS [NUM_ROWS] = '{
    // table size 8 from reset
    '{1'b0, 5'd0,  8'h00, 1'b1, 1'b1, 31'd0, 32'd0},  // zero byte from clear CRC hashes to 0
    '{1'b0, 5'd0,  8'hFF, 1'b1, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h61, 1'b0, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h00, 1'b0, 1'b0, 31'd0, 32'd0},  // zero byte mid-key is data
    '{1'b0, 5'd0,  8'h62, 1'b1, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h00, 1'b0, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h00, 1'b0, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h00, 1'b1, 1'b1, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h80, 1'b0, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h01, 1'b1, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h55, 1'b0, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'hAA, 1'b1, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h7F, 1'b1, 1'b0, 31'd0, 32'd0},
    // table size 1, two buckets
    '{1'b1, 5'd1,  8'hFE, 1'b1, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h31, 1'b1, 1'b0, 31'd0, 32'd0},
    // largest table
    '{1'b1, 5'd31, 8'hFF, 1'b0, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'hFF, 1'b0, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'hFF, 1'b0, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'hFF, 1'b1, 1'b0, 31'd0, 32'd0},
    '{1'b0, 5'd0,  8'h01, 1'b1, 1'b0, 31'd0, 32'd0},
    // empty mask: bucket always 0
    '{1'b1, 5'd0,  8'h00, 1'b1, 1'b1, 31'd0, 32'd0},
    '{1'b1, 5'd0,  8'hA5, 1'b1, 1'b0, 31'd0, 32'd0}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 key_byte = 8'h00;
  logic                       is_last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [30:0]                bucket_index;
  logic [31:0]                mixed_hash;
  logic                       cfg_we = 1'b0;
  logic [skhi_pkg::CFG_W-1:0] cfg_wdata = '0;

  string_key_hash_index_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_byte     (key_byte),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bucket_index (bucket_index),
    .mixed_hash   (mixed_hash),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [31:0]                crc_acc = '0;
  logic [skhi_pkg::CFG_W-1:0] table_log2 = 5'd8;
  hash_result_t               pending_hashes [$];

  int err_count    = 0;
  int bytes_sent   = 0;
  int keys_sent    = 0;
  int hashes_seen  = 0;
  int cfg_writes   = 0;
  int cycle_count  = 0;
  int burst_left   = 0;
  int gap_max      = 4;
  int hold_req     = 0;

  function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ skhi_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Integer mix, drop 3 bits, golden-ratio multiply; all mod 2^32.
  function automatic logic [31:0] key_hash(input logic [31:0] crc);
    logic [31:0] k;
    logic [31:0] h;
    k = crc;
    k = k + (k << 12);
    k = k ^ (k >> 22);
    k = k + (k << 4);
    k = k ^ (k >> 9);
    k = k + (k << 10);
    k = k ^ (k >> 2);
    k = k + (k << 7);
    k = k ^ (k >> 12);
    h = (k >> 3) * skhi_pkg::GOLDEN_MULT;
    return h;
  endfunction

  function automatic logic [30:0] bucket_of(input logic [31:0] h,
                                            input logic [skhi_pkg::CFG_W-1:0] lg);
    logic [31:0] mask;
    mask = (lg == '0) ? 32'd0 : ((32'd1 << lg) - 32'd1);
    return h[30:0] & mask[30:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("[%0t] MISMATCH %s: got %08h expected %08h", $realtime, what, got, want);
  endtask

  // Bursts of random length separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic [30:0] eb, input logic [31:0] eh);
    hash_result_t r;
    pace_sender();
    in_valid <= 1'b1;
    key_byte <= b;
    is_last  <= last;
    do @(posedge clk); while (!in_ready);
    // transfer happened at this edge
    bytes_sent++;
    crc_acc = crc_step(crc_acc, b);
    if (last) begin
      r.hash   = key_hash(crc_acc);
      r.bucket = bucket_of(r.hash, table_log2);
      if (typed) begin
        r.bucket = eb;
        r.hash   = eh;
      end
      pending_hashes.push_back(r);
      crc_acc = '0;
      keys_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [skhi_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    table_log2 = v;
    cfg_writes++;
  endtask

  task automatic send_key(input int len);
    logic [7:0] b;
    int sel;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 9);
      b = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      send_byte(b, (i == len - 1), 1'b0, '0, '0);
    end
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    hash_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("result with nothing pending", mixed_hash, 32'd0);
      end else begin
        want = pending_hashes.pop_front();
        hashes_seen++;
        if (bucket_index !== want.bucket)
          report_mismatch("bucket_index", {1'b0, bucket_index}, {1'b0, want.bucket});
        if (mixed_hash !== want.hash)
          report_mismatch("mixed_hash", mixed_hash, want.hash);
      end
    end
  end

  // Receiver: long hold on request, otherwise its own stall pattern.
  int rx_mode = 0, rx_left = 0, hold_left = 0, hold_seen = 0, rx_tick = 0;
  always @(posedge clk) begin
    rx_tick++;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 96);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((rx_tick % 4) != 3);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_hashes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [skhi_pkg::CFG_W-1:0] phase_cfg;
    int phase_sent;
    int len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (KEY_ROWS[i].do_cfg) begin
        wait_drained();
        write_table_size(KEY_ROWS[i].cfg);
      end
      send_byte(KEY_ROWS[i].b, KEY_ROWS[i].last, KEY_ROWS[i].typed,
                KEY_ROWS[i].eb, KEY_ROWS[i].eh);
    end

    // random part, one table size per phase; sender idles fully between phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: phase_cfg = 5'd8;
        1: phase_cfg = 5'd1;
        2: phase_cfg = 5'd31;
        3: phase_cfg = 5'd0;
        4: phase_cfg = 5'd16;
        5: phase_cfg = 5'd3;
        default: phase_cfg = 5'($urandom_range(0, 31));
      endcase
      wait_drained();
      write_table_size(phase_cfg);
      gap_max = (ph % 3 == 1) ? 0 : $urandom_range(1, 8);
      if (ph == PRESSURE_PH) begin
        // receiver holds off while short keys pour in, filling the queue
        hold_req <= hold_req + 1;
        gap_max = 0;
      end
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        if (ph == PRESSURE_PH)
          len = $urandom_range(1, 2);
        else if ($urandom_range(0, 9) == 0)
          len = $urandom_range(9, 40);
        else
          len = $urandom_range(1, 8);
        send_key(len);
        phase_sent += len;
      end
    end

    wait_drained();
    $display("%0d bytes in %0d keys, %0d hashes checked, %0d table size writes",
             bytes_sent, keys_sent, hashes_seen, cfg_writes);
    $display("table sizes covered 0, 1, 8, 16, 31 and random; %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/skhi_pkg.sv
rtl/core/skhi_front.sv
rtl/core/skhi_queue.sv
rtl/core/skhi_back.sv
rtl/core/string_key_hash_index_core.sv
sim/string_key_hash_index_core_tb.sv
